// ===== sv/nearest_predecessor_graph_defines.svh =====
// Assertion macros shared by the nearest predecessor graph checkers.
`ifndef NEAREST_PREDECESSOR_GRAPH_DEFINES_SVH
`define NEAREST_PREDECESSOR_GRAPH_DEFINES_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define NPG_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("npg assertion failed: %m");

// Same, on the block's own clock and reset names.
`define NPG_ASSERT(lbl, prop) `NPG_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

// ===== sv/npg_pkg.sv =====
// Constants, codes and transfer types of the nearest predecessor graph.
package npg_pkg;

  localparam int MAX_POINTS = 4096;
  localparam int NEIGHBOURS = 3;
  localparam int COORD_BITS = 16;

  localparam int ADDR_W = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int NB_W   = $clog2(NEIGHBOURS + 1);
  localparam int K_W    = (NEIGHBOURS > 1) ? $clog2(NEIGHBOURS) : 1;
  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int SUM_W  = SQ_W + 1;

  localparam int IDX_W  = 12;
  localparam int DIST_W = 33;
  localparam int IN_COORD_W = 16;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    ST_EDGE    = 2'd0,
    ST_FIRST   = 2'd1,
    ST_FULL    = 2'd2,
    ST_CLEARED = 2'd3
  } status_e;

  typedef struct packed {
    logic                  command;
    logic [IN_COORD_W-1:0] x_coord;
    logic [IN_COORD_W-1:0] y_coord;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  point_index;
    logic [IDX_W-1:0]  neighbour_index;
    logic [DIST_W-1:0] squared_distance;
    status_e           status;
    logic              last;
  } out_item_t;

endpackage

// ===== sv/nearest_predecessor_graph.sv =====
// Top level of the nearest predecessor graph: point store, distance scan, top-k list.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+--------------------------------
//   in      | input     | in_valid_i/in_stall_o   | in_data_i  (command, x, y)
//   out     | output    | out_valid_o/out_stall_i | out_data_o (one edge/status)
//
// Clear, store-full and first-point commands are answered with one transfer.
// An added point with N predecessors holds the block while it reads the N stored
// points, while the last reads finish in S_DRAIN, and while it emits its edges (at most
// NEIGHBOURS); the scan is bound by the single read port, one predecessor per cycle.
// Reset clears the point count and the control state; store contents are left.
// A stalled output holds its transfer; a new input is taken once the block is idle
// and the output register is free or draining.
module nearest_predecessor_graph (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  npg_pkg::in_item_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output npg_pkg::out_item_t out_data_o
);
  import npg_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;  // issuing store reads
  localparam logic [1:0] S_DRAIN = 2'd2;  // last reads still in the pipe
  localparam logic [1:0] S_EMIT  = 2'd3;  // sending the sorted edges

  logic [1:0] state_q, state_d;

  // point store, one write and one registered read port
  logic [SQ_W-1:0] mem [MAX_POINTS];
  logic [SQ_W-1:0] rd_q;

  logic [CNT_W-1:0]      count_q, count_d;
  logic [ADDR_W-1:0]     me_q, me_d;
  logic [ADDR_W-1:0]     scan_q, scan_d;
  logic [COORD_BITS-1:0] px_q, px_d, py_q, py_d;

  // pipeline: read data -> squares -> sum and insert
  logic              v1_q, last1_q;
  logic [ADDR_W-1:0] idx1_q;
  logic              v2_q, last2_q;
  logic [ADDR_W-1:0] idx2_q;
  logic [SQ_W-1:0]   sqx_q, sqy_q;

  // sorted nearest list
  logic [SUM_W-1:0]      best_d_q [NEIGHBOURS];
  logic [SUM_W-1:0]      best_d_d [NEIGHBOURS];
  logic [ADDR_W-1:0]     best_i_q [NEIGHBOURS];
  logic [ADDR_W-1:0]     best_i_d [NEIGHBOURS];
  logic [NEIGHBOURS-1:0] best_v_q, best_v_d;
  logic [K_W-1:0]        emit_k_q, emit_k_d;

  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  logic                  in_fire, out_free, add_ok, we, re;
  logic [SUM_W-1:0]      cand_dist;
  logic [NEIGHBOURS-1:0] lt;
  logic [NEIGHBOURS:0]   v_ext;
  logic [NB_W-1:0]       k_next;
  logic                  emit_last;
  logic [COORD_BITS-1:0] in_x, in_y, mx, my, dx, dy;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign add_ok     = (count_q != CNT_W'(MAX_POINTS));
  assign we         = in_fire && (in_data_i.command == CMD_ADD) && add_ok;
  assign re         = (state_q == S_SCAN);

  assign in_x = in_data_i.x_coord[COORD_BITS-1:0];
  assign in_y = in_data_i.y_coord[COORD_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[count_q[ADDR_W-1:0]] <= {in_x, in_y};
    end
    if (re) begin
      rd_q <= mem[scan_q];
    end
  end

  // stage 1: absolute differences and squares
  assign mx = rd_q[SQ_W-1:COORD_BITS];
  assign my = rd_q[COORD_BITS-1:0];
  assign dx = (px_q > mx) ? (px_q - mx) : (mx - px_q);
  assign dy = (py_q > my) ? (py_q - my) : (my - py_q);

  always_ff @(posedge clk_i) begin
    sqx_q  <= SQ_W'(dx) * SQ_W'(dx);
    sqy_q  <= SQ_W'(dy) * SQ_W'(dy);
    idx2_q <= idx1_q;
    idx1_q <= scan_q;
  end

  // stage 2: sum and sorted insert; strict compare keeps the lower index on ties
  assign cand_dist = SUM_W'(sqx_q) + SUM_W'(sqy_q);

  always_comb begin
    for (int k = 0; k < NEIGHBOURS; k++) begin
      lt[k] = !best_v_q[k] || (cand_dist < best_d_q[k]);
    end
  end

  assign v_ext     = {1'b0, best_v_q};
  assign k_next    = NB_W'(emit_k_q) + NB_W'(1);
  assign emit_last = !v_ext[k_next];

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    me_d        = me_q;
    scan_d      = scan_q;
    px_d        = px_q;
    py_d        = py_q;
    best_d_d    = best_d_q;
    best_i_d    = best_i_q;
    best_v_d    = best_v_q;
    emit_k_d    = emit_k_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    if (in_fire) begin
      out_valid_d = 1'b1;
      out_d       = '0;
      out_d.last  = 1'b1;
      if (in_data_i.command == CMD_CLEAR) begin
        count_d      = '0;
        out_d.status = ST_CLEARED;
      end else if (!add_ok) begin
        out_d.status = ST_FULL;
      end else begin
        count_d = count_q + CNT_W'(1);
        me_d    = count_q[ADDR_W-1:0];
        px_d    = in_x;
        py_d    = in_y;
        if (count_q == '0) begin
          out_d.status = ST_FIRST;
        end else begin
          out_valid_d = 1'b0;
          state_d     = S_SCAN;
          scan_d      = '0;
          best_v_d    = '0;
        end
      end
    end

    case (state_q)
      S_SCAN: begin
        scan_d = scan_q + ADDR_W'(1);
        if (scan_q == me_q - ADDR_W'(1)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (v2_q && last2_q) begin
          state_d  = S_EMIT;
          emit_k_d = '0;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d            = 1'b1;
          out_d.point_index      = IDX_W'(me_q);
          out_d.neighbour_index  = IDX_W'(best_i_q[emit_k_q]);
          out_d.squared_distance = DIST_W'(best_d_q[emit_k_q]);
          out_d.status           = ST_EDGE;
          out_d.last             = emit_last;
          emit_k_d               = emit_k_q + K_W'(1);
          if (emit_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
      end
    endcase

    if (v2_q) begin
      if (lt[0]) begin
        best_d_d[0] = cand_dist;
        best_i_d[0] = idx2_q;
        best_v_d[0] = 1'b1;
      end
      for (int k = 1; k < NEIGHBOURS; k++) begin
        if (lt[k]) begin
          if (lt[k-1]) begin
            best_d_d[k] = best_d_q[k-1];
            best_i_d[k] = best_i_q[k-1];
            best_v_d[k] = best_v_q[k-1];
          end else begin
            best_d_d[k] = cand_dist;
            best_i_d[k] = idx2_q;
            best_v_d[k] = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      v1_q        <= 1'b0;
      last1_q     <= 1'b0;
      v2_q        <= 1'b0;
      last2_q     <= 1'b0;
      best_v_q    <= '0;
      emit_k_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      v1_q        <= re;
      last1_q     <= re && (scan_q == me_q - ADDR_W'(1));
      v2_q        <= v1_q;
      last2_q     <= last1_q;
      best_v_q    <= best_v_d;
      emit_k_q    <= emit_k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    me_q     <= me_d;
    scan_q   <= scan_d;
    px_q     <= px_d;
    py_q     <= py_d;
    best_d_q <= best_d_d;
    best_i_q <= best_i_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== sv/npg_checker.sv =====
// Port-level checker for the nearest predecessor graph, with its bind.
`include "nearest_predecessor_graph_defines.svh"

module npg_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input npg_pkg::in_item_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input npg_pkg::out_item_t out_data_o
);
  import npg_pkg::*;

  // held output stays put
  `NPG_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))

  // an edge always points back to an earlier index
  `NPG_ASSERT(a_edge_back, out_valid_o && out_data_o.status == ST_EDGE |-> out_data_o.neighbour_index < out_data_o.point_index)

  // non-edge results are single transfers
  `NPG_ASSERT(a_single_last, out_valid_o && out_data_o.status != ST_EDGE |-> out_data_o.last)

  // a clear answers in the next cycle
  `NPG_ASSERT(a_clear_resp, in_valid_i && !in_stall_o && in_data_i.command == CMD_CLEAR |=> out_valid_o && out_data_o.status == ST_CLEARED)

endmodule

bind nearest_predecessor_graph npg_checker u_npg_checker (.*);

// ===== dv/nearest_predecessor_graph_tb.sv =====
// Self-checking testbench for nearest_predecessor_graph: directed table and random graph.
module nearest_predecessor_graph_tb;
  import npg_pkg::*;

  // About 140 commands; the point set never holds more than that, so each add
  // reads at most that many stored points. The cycle limit on the whole run
  // leaves a wide margin.
  localparam int CYCLE_LIMIT   = 200_000;
  localparam int RANDOM_ITEMS  = 120;
  localparam int HOLD_CYCLES   = 300;  // long receiver hold-off, fills the block up
  localparam int DRAIN_CYCLES  = 40;   // quiet time after the last result
  localparam int PRINT_CAP     = 40;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  in_item_t           in_data_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  out_item_t          out_data_o;

  nearest_predecessor_graph u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of the point set.
  // ---------------------------------------------------------------------------
  logic [IN_COORD_W-1:0] pt_x [MAX_POINTS];
  logic [IN_COORD_W-1:0] pt_y [MAX_POINTS];
  int                    stored_pts = 0;

  out_item_t new_edges_q[$];      // results of the item just taken
  out_item_t pending_edges_q[$];  // results still owed by the block, oldest first

  // Counters for checking and the closing summary.
  int mismatch_count = 0;
  int results_seen   = 0;
  int transfers_in   = 0;
  int clears_sent    = 0;
  int edges_seen     = 0;
  int cycle_count    = 0;

  // Traffic shaping knobs, set by the stimulus thread.
  bit gaps_on  = 1'b1;  // sender idles now and then
  bit stall_on = 1'b1;  // receiver stalls now and then
  bit hold_req = 1'b0;  // ask the receiver for one long hold-off

  // Exact squared distance, unsigned integer (33.0 fixed point) in a 33-bit field.
  function automatic logic [DIST_W-1:0] sq_dist(input logic [IN_COORD_W-1:0] ax,
                                                input logic [IN_COORD_W-1:0] ay,
                                                input logic [IN_COORD_W-1:0] bx,
                                                input logic [IN_COORD_W-1:0] by);
    logic [DIST_W-1:0] dx, dy;
    dx = (ax > bx) ? DIST_W'(ax - bx) : DIST_W'(bx - ax);
    dy = (ay > by) ? DIST_W'(ay - by) : DIST_W'(by - ay);
    return dx * dx + dy * dy;
  endfunction

  // Apply one command to the point set and list the results it causes.
  function automatic void predict_edges(input in_item_t item);
    logic [DIST_W-1:0] near_d [NEIGHBOURS];
    int                near_i [NEIGHBOURS];
    logic [DIST_W-1:0] d;
    int                kept, slot, me;
    out_item_t         r;
    new_edges_q.delete();
    r      = '0;
    r.last = 1'b1;
    if (item.command == CMD_CLEAR) begin
      stored_pts  = 0;
      r.status    = ST_CLEARED;
      new_edges_q = {new_edges_q, r};
      return;
    end
    if (stored_pts >= MAX_POINTS) begin
      // store full: point dropped, set untouched
      r.status    = ST_FULL;
      new_edges_q = {new_edges_q, r};
      return;
    end
    me         = stored_pts;
    pt_x[me]   = item.x_coord;
    pt_y[me]   = item.y_coord;
    stored_pts = me + 1;
    if (me == 0) begin
      r.status    = ST_FIRST;
      new_edges_q = {new_edges_q, r};
      return;
    end
    // Sorted top-k list. A new distance lands behind every kept entry with an
    // equal or smaller distance, so on a tie the lower index stays ahead.
    kept = 0;
    for (int j = 0; j < me; j++) begin
      d    = sq_dist(item.x_coord, item.y_coord, pt_x[j], pt_y[j]);
      slot = 0;
      while (slot < kept && near_d[slot] <= d) slot++;
      if (slot < NEIGHBOURS) begin
        for (int k = NEIGHBOURS - 1; k > slot; k--) begin
          near_d[k] = near_d[k-1];
          near_i[k] = near_i[k-1];
        end
        near_d[slot] = d;
        near_i[slot] = j;
        if (kept < NEIGHBOURS) kept++;
      end
    end
    for (int k = 0; k < kept; k++) begin
      r.point_index      = IDX_W'(me);
      r.neighbour_index  = IDX_W'(near_i[k]);
      r.squared_distance = near_d[k];
      r.status           = ST_EDGE;
      r.last             = (k == kept - 1);
      new_edges_q        = {new_edges_q, r};
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < PRINT_CAP)
      $display("[%0t] mismatch on %s in result %0d: got 0x%0h, want 0x%0h",
               $time, what, results_seen, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Input side. Drives at the falling edge, sees the transfer at the rising edge.
  // Expectations are queued the moment the transfer happens; either the typed
  // result of a table row or whatever the predictor gives.
  // ---------------------------------------------------------------------------
  task automatic send_command(input in_item_t item, input bit typed, input out_item_t want);
    @(negedge clk_i);
    while (gaps_on && $urandom_range(99) < 12) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    transfers_in++;
    if (item.command == CMD_CLEAR) clears_sent++;
    predict_edges(item);
    if (typed) pending_edges_q = {pending_edges_q, want};
    else pending_edges_q = {pending_edges_q, new_edges_q};
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stalls, plus one long hold-off counted here, so the
  // block backs up and has to stall its input while the sender keeps offering.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= stall_on && ($urandom_range(99) < 12);
      end
    end
  end

  // Result checker: each transfer against the oldest expectation, field by field.
  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_edges_q.size() == 0) begin
        report_mismatch("unexpected transfer", 64'(out_data_o), 64'd0);
      end else begin
        want = pending_edges_q.pop_front();
        if (out_data_o.point_index !== want.point_index)
          report_mismatch("point_index", 64'(out_data_o.point_index), 64'(want.point_index));
        if (out_data_o.neighbour_index !== want.neighbour_index)
          report_mismatch("neighbour_index", 64'(out_data_o.neighbour_index),
                          64'(want.neighbour_index));
        if (out_data_o.squared_distance !== want.squared_distance)
          report_mismatch("squared_distance", 64'(out_data_o.squared_distance),
                          64'(want.squared_distance));
        if (out_data_o.status !== want.status)
          report_mismatch("status", 64'(out_data_o.status), 64'(want.status));
        if (out_data_o.last !== want.last)
          report_mismatch("last", 64'(out_data_o.last), 64'(want.last));
        if (want.status == ST_EDGE) edges_seen++;
      end
      results_seen++;
    end
  end

  // Hang guard.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[%0t] timeout, %0d results still owed", $time, pending_edges_q.size());
    $display("nearest_predecessor_graph_tb: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Directed table: extremes, ties, duplicates, clear on an empty set.
  // Rows with a typed result hold the answer that is obvious by hand.
  // ---------------------------------------------------------------------------
  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } probe_row_t;

  probe_row_t probe_table[$];

  task automatic add_row(input logic cmd, input logic [15:0] x, input logic [15:0] y,
                         input bit typed, input int pidx, input int nidx,
                         input logic [DIST_W-1:0] want_dist, input status_e st);
    probe_row_t row;
    row.item.command          = cmd;
    row.item.x_coord          = x;
    row.item.y_coord          = y;
    row.typed                 = typed;
    row.want.point_index      = IDX_W'(pidx);
    row.want.neighbour_index  = IDX_W'(nidx);
    row.want.squared_distance = want_dist;
    row.want.status           = st;
    row.want.last             = 1'b1;
    probe_table               = {probe_table, row};
  endtask

  initial begin : stimulus
    in_item_t          item;
    logic [15:0]       last_x, last_y;
    int                pick, src;
    last_x = '0;
    last_y = '0;

    // clear on a fresh block, then the first point at the origin
    add_row(CMD_CLEAR, 16'h0000, 16'h0000, 1, 0, 0, '0, ST_CLEARED);
    add_row(CMD_ADD,   16'h0000, 16'h0000, 1, 0, 0, '0, ST_FIRST);
    // opposite corner: largest possible distance
    add_row(CMD_ADD,   16'hFFFF, 16'hFFFF, 1, 1, 0, 33'h1_FFFC_0002, ST_EDGE);
    // remaining corners and the center: many tied distances, lower index first
    add_row(CMD_ADD,   16'h0000, 16'hFFFF, 0, 0, 0, '0, ST_EDGE);
    add_row(CMD_ADD,   16'hFFFF, 16'h0000, 0, 0, 0, '0, ST_EDGE);
    add_row(CMD_ADD,   16'h8000, 16'h8000, 0, 0, 0, '0, ST_EDGE);
    // exact duplicate of index 0: zero distance
    add_row(CMD_ADD,   16'h0000, 16'h0000, 0, 0, 0, '0, ST_EDGE);
    add_row(CMD_ADD,   16'h1234, 16'h5678, 0, 0, 0, '0, ST_EDGE);
    add_row(CMD_CLEAR, 16'hFFFF, 16'hFFFF, 1, 0, 0, '0, ST_CLEARED);
    // alternating bit patterns, coordinates ignored on clear above
    add_row(CMD_ADD,   16'hAAAA, 16'h5555, 1, 0, 0, '0, ST_FIRST);
    add_row(CMD_ADD,   16'h5555, 16'hAAAA, 0, 0, 0, '0, ST_EDGE);
    add_row(CMD_ADD,   16'hAAAA, 16'h5555, 0, 0, 0, '0, ST_EDGE);
    add_row(CMD_CLEAR, 16'h0000, 16'h0000, 1, 0, 0, '0, ST_CLEARED);
    // clear while already empty
    add_row(CMD_CLEAR, 16'h0000, 16'h0000, 1, 0, 0, '0, ST_CLEARED);
    add_row(CMD_ADD,   16'h0000, 16'h0000, 1, 0, 0, '0, ST_FIRST);
    // one LSB apart: smallest nonzero distance
    add_row(CMD_ADD,   16'h0000, 16'h0001, 1, 1, 0, 33'd1, ST_EDGE);
    add_row(CMD_ADD,   16'h0001, 16'h0000, 0, 0, 0, '0, ST_EDGE);
    add_row(CMD_ADD,   16'h0001, 16'h0001, 0, 0, 0, '0, ST_EDGE);
    add_row(CMD_ADD,   16'hFFFF, 16'h0000, 0, 0, 0, '0, ST_EDGE);
    add_row(CMD_ADD,   16'h0001, 16'h0001, 0, 0, 0, '0, ST_EDGE);

    // single reset pulse at the start
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (probe_table[r]) send_command(probe_table[r].item, probe_table[r].typed,
                                          probe_table[r].want);

    // Random graph: mostly adds with clustered, duplicate and corner
    // coordinates so ties and short distances come up often; clears are rare
    // so the set grows to a few dozen points between them.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 30) hold_req = 1'b1;               // long output hold-off
      gaps_on  = !(n >= 70 && n < 110);           // stretch with no idling
      stall_on = gaps_on;
      pick         = $urandom_range(99);
      item.command = CMD_ADD;
      item.x_coord = 16'($urandom());
      item.y_coord = 16'($urandom());
      if (pick < 5) begin
        item.command = CMD_CLEAR;
      end else if (pick < 18 && stored_pts > 0) begin
        src          = $urandom_range(stored_pts - 1);
        item.x_coord = pt_x[src];
        item.y_coord = pt_y[src];
      end else if (pick < 30) begin
        case ($urandom_range(2))
          0:       item.x_coord = 16'h0000;
          1:       item.x_coord = 16'hFFFF;
          default: ;
        endcase
        case ($urandom_range(2))
          0:       item.y_coord = 16'h0000;
          1:       item.y_coord = 16'hFFFF;
          default: ;
        endcase
      end else if (pick < 60) begin
        // near the last point, wrap-around is fine
        item.x_coord = last_x + 16'($urandom_range(6)) - 16'd3;
        item.y_coord = last_y + 16'($urandom_range(6)) - 16'd3;
      end
      if (item.command == CMD_ADD) begin
        last_x = item.x_coord;
        last_y = item.y_coord;
      end
      send_command(item, 1'b0, '0);
    end

    // a clear brings the set back to its first point
    gaps_on  = 1'b1;
    stall_on = 1'b1;
    item     = '0;
    item.command = CMD_CLEAR;
    send_command(item, 1'b0, '0);
    item.command = CMD_ADD;
    item.x_coord = 16'hFFFF;
    item.y_coord = 16'h0000;
    send_command(item, 1'b0, '0);

    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // every result in, then a quiet spell to catch anything extra
    while (pending_edges_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d commands (%0d clears), %0d results checked, %0d edges",
             transfers_in, clears_sent, results_seen, edges_seen);
    $display("one receiver hold-off of %0d cycles, %0d cycles in all",
             HOLD_CYCLES, cycle_count);
    if (mismatch_count == 0 && pending_edges_q.size() == 0) begin
      $display("nearest_predecessor_graph_tb: clean");
    end else begin
      $display("nearest_predecessor_graph_tb: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/npg_pkg.sv
sv/nearest_predecessor_graph.sv
sv/npg_checker.sv
dv/nearest_predecessor_graph_tb.sv
